// ----- sv/handle_registry_set_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the handle registry set unit
// Property forms shared by the assertions of the block's top RTL file.
// ---------------------------------------------------------------------------
`ifndef HANDLE_REGISTRY_SET_UNIT_ASSERT_SVH
`define HANDLE_REGISTRY_SET_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrs assertion failed");

`endif

// ----- sv/hrs_pkg.sv -----
// ---------------------------------------------------------------------------
// Handle registry set package
// Item types, operation and status codes shared by the block's files.
// ---------------------------------------------------------------------------
package hrs_pkg;

   localparam int HANDLE_W = 64;
   localparam int CNT_W    = 5;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_VALIDATE = 2'd2,
      OP_CLEAR    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_NO_SPACE  = 3'd3,
      ST_UNKNOWN   = 3'd4
   } status_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [HANDLE_W-1:0]   handle;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [HANDLE_W-1:0]   checked_handle;
      logic [CNT_W-1:0]      entry_count;
   } rsp_type;

endpackage

// ----- sv/hrs_cmp.sv -----
// ---------------------------------------------------------------------------
// Handle registry set compare unit
// Shared equality comparator used once per scanned entry.
// ---------------------------------------------------------------------------
module hrs_cmp (
   input  logic                   cmp_valid,
   input  logic [63:0]            stored_handle,
   input  logic [63:0]            probe_handle,
   output logic                   hit
);
   import hrs_pkg::*;

   // A hit needs live store data that equals the probed handle.
   assign hit = cmp_valid && (stored_handle == probe_handle);

endmodule

// ----- sv/hrs_store.sv -----
// ---------------------------------------------------------------------------
// Handle registry set store
// Handle memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module hrs_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [hrs_pkg::HANDLE_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [hrs_pkg::HANDLE_W-1:0] rd_data
);
   import hrs_pkg::*;

   logic [HANDLE_W-1:0] mem [DEPTH];
   logic [HANDLE_W-1:0] rd_data_ff;

   // Write port; the store itself does not stop entries from being read before they were written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port: data appears in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/handle_registry_set_unit.sv -----
// ---------------------------------------------------------------------------
// Handle registry set unit
// Bounded unordered set of 64-bit handles with add, remove by swap with
// the last entry, validate and clear, one result item per request item.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Ports                                 Content
//   req      in         req_valid, req_ready, req_item        opcode, handle
//   rsp      out        rsp_valid, rsp_ready, rsp_item        status, handle, count
//   csr      in         csr_valid, csr_ready, csr_data        capacity
//
// An item with a nonzero handle passes through an accept step, a scan of one
// stored entry per cycle through the single memory read port and the shared
// comparator, a last scan step for the final compare, a decide step and a
// finish step; a hit ends the scan early, and a remove that hits adds a read
// and a write of the last entry before the finish. A clear goes from accept
// straight to finish, and a zero handle skips the scan.
// The request side is ready only while idle; a result waiting in the output
// register does not block acceptance, but the finish cycle waits for it.
// Reset clears the count and restores the capacity to 16; no clearing pass.
// ---------------------------------------------------------------------------
module handle_registry_set_unit #(
   parameter int MAX_HANDLES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hrs_pkg::req_type     req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hrs_pkg::rsp_type     rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [hrs_pkg::CNT_W-1:0] csr_data
);
   import hrs_pkg::*;

   `include "handle_registry_set_unit_assert.svh"

   localparam int AW = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MOVE_RD,
      S_MOVE_WR,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    cap_ff, cap_in;
   opcode_type          op_ff, op_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic                found_ff, found_in;
   status_type          status_ff, status_in;
   logic [HANDLE_W-1:0] checked_ff, checked_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [HANDLE_W-1:0] wr_data;
   logic [AW-1:0]       rd_addr;
   logic [HANDLE_W-1:0] rd_data;
   logic                hit;
   logic                rsp_free;
   logic [CNT_W-1:0]    eff_cap;

   hrs_store #(
      .DEPTH (MAX_HANDLES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hrs_cmp u_cmp (
      .cmp_valid     (pend_ff),
      .stored_handle (rd_data),
      .probe_handle  (handle_ff),
      .hit           (hit)
   );

   // Handshakes and the capacity saturated to the built store depth.
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (int'(cap_ff) > MAX_HANDLES) begin
         eff_cap = CNT_W'(MAX_HANDLES);
      end else begin
         eff_cap = cap_ff;
      end
   end

   // Sequencer: scan, decide, swap move, each where needed, then result.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      op_in        = op_ff;
      handle_in    = handle_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      slot_in      = slot_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      checked_in   = checked_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = handle_ff;
      rd_addr      = AW'(issue_ff);

      if (csr_valid) begin
         cap_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_item.opcode;
               handle_in  = req_item.handle;
               issue_in   = '0;
               found_in   = 1'b0;
               status_in  = ST_OK;
               checked_in = '0;
               if (req_item.opcode == OP_CLEAR) begin
                  count_in = '0;
                  state_in = S_FINISH;
               end else if (req_item.handle == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               found_in = 1'b1;
               state_in = S_DECIDE;
            end else if (issue_ff < count_ff) begin
               pend_in  = 1'b1;
               slot_in  = AW'(issue_ff);
               issue_in = issue_ff + CNT_W'(1);
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            unique case (op_ff)
               OP_ADD: begin
                  if (handle_ff == '0) begin
                     status_in = ST_INVALID;
                  end else if (found_ff) begin
                     status_in = ST_DUPLICATE;
                  end else if (count_ff >= eff_cap) begin
                     status_in = ST_NO_SPACE;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(count_ff);
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_REMOVE: begin
                  if (handle_ff == '0) begin
                     status_in = ST_INVALID;
                  end else if (!found_ff) begin
                     status_in = ST_UNKNOWN;
                  end else begin
                     state_in = S_MOVE_RD;
                  end
               end
               OP_VALIDATE: begin
                  checked_in = found_ff ? handle_ff : '0;
               end
               OP_CLEAR: begin
                  status_in = ST_OK;
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         S_MOVE_RD: begin
            // Fetch the last entry to fill the hole left by the removal.
            rd_addr  = AW'(count_ff - CNT_W'(1));
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = rd_data;
            count_in = count_ff - CNT_W'(1);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.checked_handle = checked_ff;
               rsp_in.entry_count    = count_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CNT_W'(16);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      handle_ff  <= handle_in;
      issue_ff   <= issue_in;
      slot_ff    <= slot_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
      checked_ff <= checked_in;
      rsp_ff     <= rsp_in;
   end

   // The count never passes the built store depth.
   `HRS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, int'(count_ff) <= MAX_HANDLES)
   // An accepted item blocks the request side for the next cycle.
   `HRS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // The scan never changes the count.
   `HRS_ASSERT_NEXT(a_scan_keeps_count, clock, reset, state_ff == S_SCAN, $stable(count_ff))
   // A swap move only happens on a non-empty set.
   `HRS_ASSERT_SAME(a_move_nonempty, clock, reset,
                    state_ff == S_MOVE_RD || state_ff == S_MOVE_WR, count_ff != '0)
   // Leaving the finish state always presents a result.
   `HRS_ASSERT_NEXT(a_finish_presents, clock, reset,
                    state_ff == S_FINISH && rsp_free, rsp_valid_ff)

endmodule

// ----- tb/hrs_result_checker.sv -----
// ---------------------------------------------------------------------------
// Handle registry set result checker
// Watches the request, result and capacity channels of the handle registry
// set unit. It keeps a shadow copy of the set, predicts one result item per
// accepted request item and compares each accepted result item, field by
// field, with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module hrs_result_checker #(
   parameter int SLOTS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  hrs_pkg::req_type          req_item,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  hrs_pkg::rsp_type          rsp_item,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [hrs_pkg::CNT_W-1:0] csr_data,
   output int                        awaiting,
   output int                        fail_count
);
   import hrs_pkg::*;

   localparam int MAX_REPORTS = 10;

   // Shadow copy of the set and of the capacity register.
   logic [HANDLE_W-1:0] shadow_handles [SLOTS];
   logic [CNT_W-1:0]    shadow_count;
   logic [CNT_W-1:0]    shadow_capacity;

   // Predicted result items, oldest first.
   rsp_type             predicted_rsps [$];
   int                  failures = 0;

   // Searches the occupied slots for a handle.
   function automatic bit find_handle(input logic [HANDLE_W-1:0] h, output int slot);
      slot = 0;
      for (int i = 0; i < int'(shadow_count); i++) begin
         if (shadow_handles[i] == h) begin
            slot = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Applies one request item to the shadow set and returns its result item.
   function automatic rsp_type apply_registry_op(input req_type r);
      rsp_type res;
      int      slot;
      int      room;
      bit      hit;
      room = (int'(shadow_capacity) > SLOTS) ? SLOTS : int'(shadow_capacity);
      hit = find_handle(r.handle, slot);
      res.status = ST_OK;
      res.checked_handle = '0;
      case (r.opcode)
         OP_ADD: begin
            if (r.handle == '0) begin
               res.status = ST_INVALID;
            end else if (hit) begin
               res.status = ST_DUPLICATE;
            end else if (int'(shadow_count) >= room) begin
               res.status = ST_NO_SPACE;
            end else begin
               shadow_handles[shadow_count] = r.handle;
               shadow_count = shadow_count + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (r.handle == '0) begin
               res.status = ST_INVALID;
            end else if (!hit) begin
               res.status = ST_UNKNOWN;
            end else begin
               // The last entry moves into the freed slot.
               shadow_handles[slot] = shadow_handles[shadow_count - 1'b1];
               shadow_count = shadow_count - 1'b1;
            end
         end
         OP_VALIDATE: begin
            if (r.handle != '0 && hit) begin
               res.checked_handle = r.handle;
            end
         end
         default: begin
            shadow_count = '0;
         end
      endcase
      res.entry_count = shadow_count;
      return res;
   endfunction

   // Counts a failure and reports the first few of them.
   task automatic flag_failure(input string what, input logic [HANDLE_W-1:0] want,
                               input logic [HANDLE_W-1:0] got);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("result check failed on %s: expected %0h, got %0h", what, want, got);
      end
   endtask

   // Results are retired before new predictions are queued, so that a result
   // item in the same cycle as a request item is matched against older ones.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_count = '0;
         shadow_capacity = 5'd16;
         predicted_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            shadow_capacity = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               flag_failure("result item with none awaited", '0, rsp_item.checked_handle);
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_item.status !== want.status) begin
                  flag_failure("status", want.status, rsp_item.status);
               end
               if (rsp_item.checked_handle !== want.checked_handle) begin
                  flag_failure("checked_handle", want.checked_handle,
                               rsp_item.checked_handle);
               end
               if (rsp_item.entry_count !== want.entry_count) begin
                  flag_failure("entry_count", want.entry_count, rsp_item.entry_count);
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted_rsps.push_back(apply_registry_op(req_item));
         end
      end
      awaiting <= predicted_rsps.size();
      fail_count <= failures;
   end

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// Handle registry set unit testbench
// Drives a directed sequence and then phases of random request items under
// varying capacities and idling patterns. The result checker beside the
// block predicts and compares every result item; this module gives the
// verdict from its failure count.
// ---------------------------------------------------------------------------
module tb_top;
   import hrs_pkg::*;

   localparam int SLOTS          = 16;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 40;
   localparam int POOL_SIZE      = 24;

   localparam logic [HANDLE_W-1:0] ALL_ONES = '1;
   localparam logic [HANDLE_W-1:0] LOW_ONE  = 64'h1;
   localparam logic [HANDLE_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [HANDLE_W-1:0] ODD_BITS = 64'h5555_5555_5555_5555;
   localparam logic [HANDLE_W-1:0] EVN_BITS = 64'hAAAA_AAAA_AAAA_AAAA;

   typedef enum int {
      GAPS_NONE,
      GAPS_SENDER,
      GAPS_RECEIVER,
      GAPS_BOTH
   } gap_mode_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_item = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_item;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data = '0;

   int               awaiting;
   int               fail_count;
   int               cycle_count = 0;
   gap_mode_type     gap_mode = GAPS_NONE;
   int               holdoffs_asked = 0;
   int               holdoffs_served = 0;
   int               holdoff_left = 0;
   logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   handle_registry_set_unit #(
      .MAX_HANDLES(SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   hrs_result_checker #(
      .SLOTS(SLOTS)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .awaiting   (awaiting),
      .fail_count (fail_count)
   );

   // Chance in percent that a side idles in a given cycle.
   function automatic int gap_pct(input gap_mode_type m, input bit receiver_side);
      case (m)
         GAPS_SENDER:   return receiver_side ? 0 : 78;
         GAPS_RECEIVER: return receiver_side ? 78 : 0;
         GAPS_BOTH:     return 9;
         default:       return 0;
      endcase
   endfunction

   // The receiver stalls at random and serves each long hold-off request by
   // keeping ready low until its hold-off counter has run down.
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if (holdoffs_served < holdoffs_asked) begin
         holdoffs_served++;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= gap_pct(gap_mode, 1'b1));
      end
   end

   // The run ends with a failure once the cycle budget is used up.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic req_type make_req(input opcode_type op, input logic [HANDLE_W-1:0] h);
      req_type r;
      r.opcode = op;
      r.handle = h;
      return r;
   endfunction

   // Most items use handles from a small pool, so that duplicates, hits and
   // a full set are common; the rest are null or fully random handles.
   function automatic req_type random_req(input int add_pct, input int pool_n);
      req_type r;
      int      pick;
      int      rem_pct;
      rem_pct = (97 - add_pct) / 2;
      pick = $urandom_range(99);
      if (pick < 3) begin
         r.opcode = OP_CLEAR;
      end else if (pick < 3 + add_pct) begin
         r.opcode = OP_ADD;
      end else if (pick < 3 + add_pct + rem_pct) begin
         r.opcode = OP_REMOVE;
      end else begin
         r.opcode = OP_VALIDATE;
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
         r.handle = '0;
      end else if (pick < 20) begin
         r.handle = {$urandom, $urandom};
      end else begin
         r.handle = handle_pool[$urandom_range(pool_n - 1)];
      end
      return r;
   endfunction

   // Offers one request item and returns at the edge where it is accepted.
   task automatic send_req(input req_type r);
      while ($urandom_range(99) < gap_pct(gap_mode, 1'b0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering items and waits until every predicted result has come.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One random phase: a capacity setting, an idling pattern and a mix.
   task automatic run_phase(input logic [CNT_W-1:0] capacity, input gap_mode_type mode,
                            input int items, input int add_pct, input int pool_n,
                            input bit pressure);
      drain_results();
      write_capacity(capacity);
      gap_mode = mode;
      for (int k = 0; k < 4; k++) begin
         handle_pool[3 + $urandom_range(POOL_SIZE - 4)] = {$urandom, $urandom};
      end
      if (pressure) begin
         holdoffs_asked++;
      end
      for (int i = 0; i < items; i++) begin
         if (pressure && i == items / 2) begin
            holdoffs_asked++;
         end
         send_req(random_req(add_pct, pool_n));
      end
   endtask

   initial begin : stimulus
      handle_pool[0] = ALL_ONES;
      handle_pool[1] = LOW_ONE;
      handle_pool[2] = TOP_BIT;
      for (int k = 3; k < POOL_SIZE; k++) begin
         handle_pool[k] = {$urandom, $urandom};
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Null handles and an empty set at the reset capacity.
      send_req(make_req(OP_VALIDATE, '0));
      send_req(make_req(OP_ADD, '0));
      send_req(make_req(OP_REMOVE, '0));
      send_req(make_req(OP_REMOVE, ALL_ONES));
      // Extreme handles, a duplicate, hits and misses, a swap removal.
      send_req(make_req(OP_ADD, ALL_ONES));
      send_req(make_req(OP_ADD, LOW_ONE));
      send_req(make_req(OP_ADD, TOP_BIT));
      send_req(make_req(OP_ADD, ALL_ONES));
      send_req(make_req(OP_VALIDATE, ALL_ONES));
      send_req(make_req(OP_VALIDATE, ODD_BITS));
      send_req(make_req(OP_REMOVE, LOW_ONE));
      send_req(make_req(OP_VALIDATE, TOP_BIT));
      send_req(make_req(OP_REMOVE, ODD_BITS));
      send_req(make_req(OP_CLEAR, EVN_BITS));
      send_req(make_req(OP_VALIDATE, ALL_ONES));

      // A single slot: a full set, and a duplicate checked before space.
      drain_results();
      write_capacity(5'd1);
      send_req(make_req(OP_ADD, ODD_BITS));
      send_req(make_req(OP_ADD, EVN_BITS));
      send_req(make_req(OP_ADD, ODD_BITS));
      send_req(make_req(OP_REMOVE, ODD_BITS));
      send_req(make_req(OP_ADD, EVN_BITS));

      // Capacity zero while one entry is held.
      drain_results();
      write_capacity(5'd0);
      send_req(make_req(OP_ADD, ODD_BITS));
      send_req(make_req(OP_VALIDATE, EVN_BITS));

      // Capacity above the store depth saturates.
      drain_results();
      write_capacity(5'd31);
      send_req(make_req(OP_ADD, ODD_BITS));
      send_req(make_req(OP_REMOVE, EVN_BITS));

      run_phase(5'd16, GAPS_NONE,     200, 45, 20, 1'b0);
      run_phase(5'd4,  GAPS_SENDER,   150, 40, 10, 1'b0);
      run_phase(5'd31, GAPS_RECEIVER, 200, 60, 24, 1'b0);
      run_phase(5'd1,  GAPS_BOTH,     100, 40,  6, 1'b0);
      run_phase(5'd16, GAPS_NONE,     150, 45, 20, 1'b1);
      run_phase(5'd8,  GAPS_BOTH,     150, 40, 16, 1'b0);
      run_phase(5'd0,  GAPS_SENDER,    50, 50,  8, 1'b0);
      run_phase(5'd12, GAPS_RECEIVER, 150, 45, 20, 1'b0);
      run_phase(5'd16, GAPS_NONE,     100, 55, 24, 1'b0);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ----- handle_registry_set_unit.f -----
+incdir+sv
sv/hrs_pkg.sv
sv/hrs_cmp.sv
sv/hrs_store.sv
sv/handle_registry_set_unit.sv
tb/hrs_result_checker.sv
tb/tb_top.sv
